[hdl/sle_pkg.sv]
// Package for the sequential list engine: sizes, request codes, decoded ops,
// queue entry type and back-end states. No dependencies.
package sle_pkg;

	localparam int CAPACITY = 64;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic [3:0] REQ_INSERT  = 4'd0;
	localparam logic [3:0] REQ_DEL_POS = 4'd1;
	localparam logic [3:0] REQ_READ    = 4'd2;
	localparam logic [3:0] REQ_LOCATE  = 4'd3;
	localparam logic [3:0] REQ_DEL_MIN = 4'd4;
	localparam logic [3:0] REQ_DEL_VAL = 4'd5;
	localparam logic [3:0] REQ_DEL_RNG = 4'd6;
	localparam logic [3:0] REQ_REVERSE = 4'd7;
	localparam logic [3:0] REQ_ROTATE  = 4'd8;

	typedef enum logic [3:0] {
		OP_INS, OP_DEL, OP_RD, OP_LOC, OP_MIN, OP_DELV, OP_DELR, OP_REV, OP_ROT, OP_BAD
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [6:0]  pos;
		logic [31:0] val;
		logic [31:0] upv;
	} req_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_INS_RD, S_INS_WR, S_INS_PUT, S_DEL_RD, S_DEL_CAP,
		S_SH_RD, S_SH_WR, S_RD_RD, S_RD_CAP, S_LOC_RD, S_LOC_CMP, S_MIN_RD,
		S_MIN_CMP, S_MIN_LRD, S_MIN_LWR, S_CMP_RD, S_CMP_WR, S_MOD,
		S_REV_RDA, S_REV_RDB, S_REV_WRA, S_REV_WRB, S_REV_NEXT, S_DONE
	} st_t;

endpackage

[hdl/sle_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[hdl/sle_front.sv]
// Front end: takes request beats, decodes the request code and holds them
// in a two-entry queue for the back end. Depends on sle_pkg.
module sle_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [3:0]    req_type,
	input  logic [6:0]    position,
	input  logic [31:0]   value,
	input  logic [31:0]   upper_value,
	output logic          q_valid,
	output sle_pkg::req_t q_head,
	input  logic          q_pop
);
	import sle_pkg::*;

	req_t       q_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;
	op_t        op;

	always_comb begin
		unique case (req_type)
			REQ_INSERT:  op = OP_INS;
			REQ_DEL_POS: op = OP_DEL;
			REQ_READ:    op = OP_RD;
			REQ_LOCATE:  op = OP_LOC;
			REQ_DEL_MIN: op = OP_MIN;
			REQ_DEL_VAL: op = OP_DELV;
			REQ_DEL_RNG: op = OP_DELR;
			REQ_REVERSE: op = OP_REV;
			REQ_ROTATE:  op = OP_ROT;
			default:     op = OP_BAD;
		endcase
	end

	assign busy    = (cnt_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_head  = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= '{op: op, pos: position, val: value, upv: upper_value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

[hdl/sle_back.sv]
// Back end: sequencer that carries out one request at a time on the element
// RAM and reports one result beat. Depends on sle_pkg and sle_ram.
module sle_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  sle_pkg::req_t q_head,
	output logic          q_pop,
	output logic          done,
	output logic          ok,
	output logic [31:0]   result_value,
	output logic [6:0]    found_position,
	output logic [6:0]    list_length
);
	import sle_pkg::*;

	st_t            st_q, st_d;
	op_t            op_q;
	logic [6:0]     pos_q;
	logic [31:0]    val_q, upv_q, res_q, min_q, tmp_q;
	logic [CW-1:0]  cnt_q, i_q, w_q, a_q, b_q, p_q;
	logic [AW-1:0]  m_q;
	logic [1:0]     ph_q;
	logic           ok_q;
	logic [6:0]     found_q;

	logic           we, re;
	logic [AW-1:0]  waddr, raddr;
	logic [31:0]    wdata, rdata;
	logic           keep, rev_go, ins_go, valid_pos;

	sle_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.re(re), .raddr(raddr), .rdata(rdata)
	);

	assign keep   = !($signed(rdata) >= $signed(val_q) && $signed(rdata) <= $signed(upv_q));
	assign rev_go = ({1'b0, a_q} + 1'b1) < {1'b0, b_q};
	assign ins_go = ({1'b0, i_q} >= {1'b0, pos_q}) && (i_q != '0);
	assign valid_pos = (pos_q != 7'd0) && ({1'b0, pos_q} <= {1'b0, cnt_q});

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			S_IDLE:    if (q_valid) st_d = S_DISP;
			S_DISP: begin
				unique case (op_q)
					OP_INS: st_d = ((pos_q != 7'd0) && ({1'b0, pos_q} <= {1'b0, cnt_q} + 1'b1)
						&& (cnt_q < CW'(CAPACITY))) ? S_INS_RD : S_DONE;
					OP_DEL:  st_d = valid_pos ? S_DEL_RD : S_DONE;
					OP_RD:   st_d = valid_pos ? S_RD_RD : S_DONE;
					OP_LOC:  st_d = S_LOC_RD;
					OP_MIN:  st_d = (cnt_q != '0) ? S_MIN_RD : S_DONE;
					OP_DELV: st_d = S_CMP_RD;
					OP_DELR: st_d = ($signed(val_q) < $signed(upv_q) && cnt_q != '0)
						? S_CMP_RD : S_DONE;
					OP_REV:  st_d = S_REV_RDA;
					OP_ROT:  st_d = (cnt_q != '0) ? S_MOD : S_DONE;
					default: st_d = S_DONE;
				endcase
			end
			S_INS_RD:  st_d = ins_go ? S_INS_WR : S_INS_PUT;
			S_INS_WR:  st_d = S_INS_RD;
			S_INS_PUT: st_d = S_DONE;
			S_DEL_RD:  st_d = S_DEL_CAP;
			S_DEL_CAP: st_d = S_SH_RD;
			S_SH_RD:   st_d = (i_q < cnt_q) ? S_SH_WR : S_DONE;
			S_SH_WR:   st_d = S_SH_RD;
			S_RD_RD:   st_d = S_RD_CAP;
			S_RD_CAP:  st_d = S_DONE;
			S_LOC_RD:  st_d = (i_q < cnt_q) ? S_LOC_CMP : S_DONE;
			S_LOC_CMP: st_d = (rdata == val_q) ? S_DONE : S_LOC_RD;
			S_MIN_RD:  st_d = (i_q < cnt_q) ? S_MIN_CMP : S_MIN_LRD;
			S_MIN_CMP: st_d = S_MIN_RD;
			S_MIN_LRD: st_d = S_MIN_LWR;
			S_MIN_LWR: st_d = S_DONE;
			S_CMP_RD:  st_d = (i_q < cnt_q) ? S_CMP_WR : S_DONE;
			S_CMP_WR:  st_d = S_CMP_RD;
			S_MOD:     st_d = (p_q >= cnt_q) ? S_MOD : S_REV_RDA;
			S_REV_RDA: st_d = rev_go ? S_REV_RDB : S_REV_NEXT;
			S_REV_RDB: st_d = S_REV_WRA;
			S_REV_WRA: st_d = S_REV_WRB;
			S_REV_WRB: st_d = S_REV_RDA;
			S_REV_NEXT: st_d = (ph_q == 2'd2) ? S_DONE : S_REV_RDA;
			S_DONE:    st_d = S_IDLE;
			default:   st_d = S_IDLE;
		endcase
	end

	always_comb begin
		q_pop = (st_q == S_IDLE) && q_valid;
		done  = (st_q == S_DONE);
		re    = 1'b0;
		raddr = i_q[AW-1:0];
		we    = 1'b0;
		waddr = i_q[AW-1:0];
		wdata = rdata;
		unique case (st_q)
			S_INS_RD: begin
				re    = 1'b1;
				raddr = AW'(i_q - 1'b1);
			end
			S_INS_WR: we = 1'b1;
			S_INS_PUT: begin
				we    = 1'b1;
				waddr = AW'(pos_q - 1'b1);
				wdata = val_q;
			end
			S_DEL_RD, S_RD_RD: begin
				re    = 1'b1;
				raddr = AW'(pos_q - 1'b1);
			end
			S_SH_RD, S_LOC_RD, S_MIN_RD, S_CMP_RD: re = 1'b1;
			S_SH_WR: begin
				we    = 1'b1;
				waddr = AW'(i_q - 1'b1);
			end
			S_MIN_LRD: begin
				re    = 1'b1;
				raddr = AW'(cnt_q - 1'b1);
			end
			S_MIN_LWR: begin
				we    = 1'b1;
				waddr = m_q;
			end
			S_CMP_WR: begin
				we    = keep;
				waddr = w_q[AW-1:0];
			end
			S_REV_RDA: begin
				re    = 1'b1;
				raddr = a_q[AW-1:0];
			end
			S_REV_RDB: begin
				re    = 1'b1;
				raddr = AW'(b_q - 1'b1);
			end
			S_REV_WRA: begin
				we    = 1'b1;
				waddr = a_q[AW-1:0];
			end
			S_REV_WRB: begin
				we    = 1'b1;
				waddr = AW'(b_q - 1'b1);
				wdata = tmp_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_IDLE;
			cnt_q <= '0;
		end else begin
			st_q <= st_d;
			unique case (st_q)
				S_INS_PUT: cnt_q <= cnt_q + 1'b1;
				S_MIN_LWR: cnt_q <= cnt_q - 1'b1;
				S_SH_RD:   if (!(i_q < cnt_q)) cnt_q <= cnt_q - 1'b1;
				S_CMP_RD:  if (!(i_q < cnt_q)) cnt_q <= w_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: begin
				op_q  <= q_head.op;
				pos_q <= q_head.pos;
				val_q <= q_head.val;
				upv_q <= (q_head.op == OP_DELV) ? q_head.val : q_head.upv;
			end
			S_DISP: begin
				ok_q    <= (op_q != OP_LOC) && (op_q != OP_BAD);
				res_q   <= '0;
				found_q <= '0;
				i_q     <= '0;
				w_q     <= '0;
				a_q     <= '0;
				b_q     <= cnt_q;
				ph_q    <= 2'd2;
				p_q     <= pos_q;
				unique case (op_q)
					OP_INS:  if (!((pos_q != 7'd0) && ({1'b0, pos_q} <= {1'b0, cnt_q} + 1'b1)
						&& (cnt_q < CW'(CAPACITY)))) ok_q <= 1'b0; else i_q <= cnt_q;
					OP_DEL, OP_RD: if (!valid_pos) ok_q <= 1'b0;
					OP_MIN:  if (cnt_q == '0) ok_q <= 1'b0;
					OP_DELR: if (!($signed(val_q) < $signed(upv_q) && cnt_q != '0)) ok_q <= 1'b0;
					default: ;
				endcase
			end
			S_INS_WR: i_q <= i_q - 1'b1;
			S_DEL_CAP: begin
				res_q <= rdata;
				i_q   <= CW'(pos_q);
			end
			S_SH_WR:  i_q <= i_q + 1'b1;
			S_RD_CAP: res_q <= rdata;
			S_LOC_CMP: begin
				if (rdata == val_q) begin
					ok_q    <= 1'b1;
					found_q <= 7'(i_q + 1'b1);
				end
				i_q <= i_q + 1'b1;
			end
			S_MIN_CMP: begin
				if (i_q == '0 || $signed(rdata) <= $signed(min_q)) begin
					min_q <= rdata;
					m_q   <= i_q[AW-1:0];
				end
				i_q <= i_q + 1'b1;
			end
			S_MIN_LRD: res_q <= min_q;
			S_CMP_WR: begin
				if (keep) w_q <= w_q + 1'b1;
				i_q <= i_q + 1'b1;
			end
			S_MOD: begin
				if (p_q >= cnt_q) begin
					p_q <= p_q - cnt_q;
				end else begin
					b_q  <= p_q;
					ph_q <= 2'd0;
				end
			end
			S_REV_RDB: tmp_q <= rdata;
			S_REV_WRB: begin
				a_q <= a_q + 1'b1;
				b_q <= b_q - 1'b1;
			end
			S_REV_NEXT: begin
				if (ph_q == 2'd0) begin
					a_q <= p_q;
					b_q <= cnt_q;
				end else begin
					a_q <= '0;
					b_q <= cnt_q;
				end
				if (ph_q != 2'd2) ph_q <= ph_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign ok             = ok_q;
	assign result_value   = res_q;
	assign found_position = found_q;
	assign list_length    = 7'(cnt_q);
endmodule

[hdl/sequential_list_engine_top.sv]
// Sequential list engine: one request per start beat, one result beat each.
// On any error decode goes straight to the result beat. Insert shifts the elements from pos
// on up from the end, delete shifts them down, locate stops at the first hit, minimum moves
// the last element into its slot, and rotate reverses the first p, the last n-p and then all
// n (p = pos mod n). The back end returns to idle after each result; the receiver cannot
// stall. A two-entry queue takes beats meanwhile. Reset clears length and queue, not the RAM.
module sequential_list_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  req_type,
	input  logic [6:0]  position,
	input  logic [31:0] value,
	input  logic [31:0] upper_value,
	output logic        done,
	output logic        ok,
	output logic [31:0] result_value,
	output logic [6:0]  found_position,
	output logic [6:0]  list_length
);
	import sle_pkg::*;

	logic q_valid, q_pop;
	req_t q_head;

	sle_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .position(position), .value(value),
		.upper_value(upper_value), .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop)
	);

	sle_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
		.done(done), .ok(ok), .result_value(result_value),
		.found_position(found_position), .list_length(list_length)
	);
endmodule

[tb/sle_list_checker.sv]
`timescale 1ns / 100ps
// Checker for the sequential list engine: watches request and result beats,
// keeps its own copy of the list and compares each result. Depends on sle_pkg.
module sle_list_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [3:0]  req_type,
	input  logic [6:0]  position,
	input  logic [31:0] value,
	input  logic [31:0] upper_value,
	input  logic        done,
	input  logic        ok,
	input  logic [31:0] result_value,
	input  logic [6:0]  found_position,
	input  logic [6:0]  list_length,
	output int          errors,
	output int          pending
);
	import sle_pkg::*;

	typedef struct packed {
		logic        ok;
		logic [31:0] rval;
		logic [6:0]  fpos;
		logic [6:0]  len;
	} list_result_t;

	logic signed [31:0] elems [CAPACITY];
	int                 elem_cnt;
	list_result_t       expected_results[$];

	function automatic void strip_between(logic signed [31:0] lo, logic signed [31:0] hi);
		int k;
		k = 0;
		for (int i = 0; i < elem_cnt; i++) begin
			if (elems[i] >= lo && elems[i] <= hi) k++;
			else elems[i - k] = elems[i];
		end
		elem_cnt -= k;
	endfunction

	function automatic list_result_t apply_request(logic [3:0] req, logic [6:0] pos,
			logic signed [31:0] val, logic signed [31:0] upv);
		list_result_t r;
		logic signed [31:0] tmp [CAPACITY];
		int m, p;
		r = '0;
		case (req)
			REQ_INSERT: if (pos >= 1 && pos <= elem_cnt + 1 && elem_cnt < CAPACITY) begin
				for (int i = elem_cnt; i >= pos; i--) elems[i] = elems[i - 1];
				elems[pos - 1] = val;
				elem_cnt++;
				r.ok = 1;
			end
			REQ_DEL_POS: if (pos >= 1 && pos <= elem_cnt) begin
				r.rval = elems[pos - 1];
				for (int i = pos; i < elem_cnt; i++) elems[i - 1] = elems[i];
				elem_cnt--;
				r.ok = 1;
			end
			REQ_READ: if (pos >= 1 && pos <= elem_cnt) begin
				r.rval = elems[pos - 1];
				r.ok = 1;
			end
			REQ_LOCATE: for (int i = 0; i < elem_cnt; i++) begin
				if (elems[i] == val) begin
					r.fpos = 7'(i + 1);
					r.ok = 1;
					break;
				end
			end
			REQ_DEL_MIN: if (elem_cnt > 0) begin
				m = 0;
				for (int i = 0; i < elem_cnt; i++) if (elems[i] <= elems[m]) m = i;
				r.rval = elems[m];
				elems[m] = elems[elem_cnt - 1];
				elem_cnt--;
				r.ok = 1;
			end
			REQ_DEL_VAL: begin
				strip_between(val, val);
				r.ok = 1;
			end
			REQ_DEL_RNG: if (val < upv && elem_cnt > 0) begin
				strip_between(val, upv);
				r.ok = 1;
			end
			REQ_REVERSE: begin
				for (int i = 0; i < elem_cnt / 2; i++) begin
					tmp[0] = elems[i];
					elems[i] = elems[elem_cnt - 1 - i];
					elems[elem_cnt - 1 - i] = tmp[0];
				end
				r.ok = 1;
			end
			REQ_ROTATE: begin
				if (elem_cnt > 0) begin
					p = pos % elem_cnt;
					for (int i = 0; i < elem_cnt; i++) tmp[i] = elems[(i + p) % elem_cnt];
					for (int i = 0; i < elem_cnt; i++) elems[i] = tmp[i];
				end
				r.ok = 1;
			end
			default: ;
		endcase
		r.len = 7'(elem_cnt);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		if (!arst_n) begin
			elem_cnt = 0;
			expected_results.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result beat with nothing expected", 32'(done), 32'd0);
				end else begin
					want = expected_results.pop_front();
					if (ok !== want.ok) report_mismatch("ok", 32'(ok), 32'(want.ok));
					if (result_value !== want.rval)
						report_mismatch("result_value", result_value, want.rval);
					if (found_position !== want.fpos)
						report_mismatch("found_position", 32'(found_position),
							32'(want.fpos));
					if (list_length !== want.len)
						report_mismatch("list_length", 32'(list_length), 32'(want.len));
				end
			end
			if (start && !busy)
				expected_results.push_back(apply_request(req_type, position, value, upper_value));
			pending = expected_results.size();
		end
	end
endmodule

[tb/sequential_list_engine_top_test.sv]
`timescale 1ns / 100ps
// Testbench top for the sequential list engine: clock, reset and request
// stimulus; verdict from sle_list_checker. Depends on sle_pkg and the RTL.
module sequential_list_engine_top_test;
	import sle_pkg::*;

	localparam logic [3:0] REQ_UNUSED_LO = 4'd9;
	localparam logic [3:0] REQ_UNUSED_HI = 4'd15;
	localparam int CYCLE_LIMIT = 3000000;

	logic        clk, arst_n, start, busy, done, ok;
	logic [3:0]  req_type;
	logic [6:0]  position, found_position, list_length;
	logic [31:0] value, upper_value, result_value;
	int          errors, pending, cycles, seen_len;
	logic [31:0] val_pool [8];

	sequential_list_engine_top dut (.*);

	sle_list_checker chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (done) seen_len = int'(list_length);
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic send_beat(logic [3:0] rq, logic [6:0] pos, logic [31:0] v, logic [31:0] u);
		@(negedge clk);
		req_type = rq;
		position = pos;
		value = v;
		upper_value = u;
		start = 1;
		while (busy) @(negedge clk);
		@(posedge clk);
		@(negedge clk);
		start = 0;
	endtask

	function automatic logic [31:0] pick_value();
		if ($urandom_range(0, 3) == 0) return $urandom();
		return val_pool[$urandom_range(0, 7)];
	endfunction

	task automatic random_beat(int fill_bias);
		logic [3:0] rq;
		logic [6:0] pos;
		logic [31:0] v, u;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < fill_bias) rq = REQ_INSERT;
		else if (sel < 97) rq = 4'($urandom_range(REQ_DEL_POS, REQ_ROTATE));
		else rq = 4'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
		case ($urandom_range(0, 9))
			0: pos = 7'($urandom());
			1: pos = 0;
			default: pos = 7'($urandom_range(1, seen_len + 1));
		endcase
		v = pick_value();
		u = pick_value();
		if (rq == REQ_DEL_RNG && $urandom_range(0, 3) != 0 && $signed(v) > $signed(u)) begin
			v = u;
			u = pick_value();
		end
		send_beat(rq, pos, v, u);
	endtask

	initial begin
		int gap;
		start = 0;
		req_type = 0;
		position = 0;
		value = 0;
		upper_value = 0;
		cycles = 0;
		seen_len = 0;
		arst_n = 0;
		for (int i = 0; i < 8; i++) val_pool[i] = $urandom();
		val_pool[0] = 32'h8000_0000;
		val_pool[1] = 32'h7fff_ffff;
		val_pool[2] = 0;
		val_pool[3] = 32'hffff_ffff;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// empty-list and edge-position corner cases
		send_beat(REQ_DEL_POS, 1, 0, 0);
		send_beat(REQ_READ, 1, 0, 0);
		send_beat(REQ_DEL_MIN, 0, 0, 0);
		send_beat(REQ_DEL_RNG, 0, 32'h8000_0000, 32'h7fff_ffff);
		send_beat(REQ_ROTATE, 5, 0, 0);
		send_beat(REQ_REVERSE, 0, 0, 0);
		send_beat(REQ_INSERT, 0, 1, 0);
		send_beat(REQ_INSERT, 2, 1, 0);
		send_beat(REQ_INSERT, 1, 32'h8000_0000, 0);
		send_beat(REQ_INSERT, 2, 32'h7fff_ffff, 0);
		send_beat(REQ_INSERT, 1, 32'h7fff_ffff, 0);
		send_beat(REQ_INSERT, 4, 32'h8000_0000, 0);
		send_beat(REQ_READ, 4, 0, 0);
		send_beat(REQ_READ, 5, 0, 0);
		send_beat(REQ_LOCATE, 0, 32'h7fff_ffff, 0);
		send_beat(REQ_LOCATE, 0, 32'h1234_5678, 0);
		send_beat(REQ_DEL_MIN, 0, 0, 0);
		send_beat(REQ_DEL_RNG, 0, 5, 5);
		send_beat(REQ_ROTATE, 127, 0, 0);
		send_beat(REQ_REVERSE, 0, 0, 0);
		send_beat(REQ_DEL_VAL, 0, 32'h7fff_ffff, 0);
		send_beat(REQ_UNUSED_LO, 1, 0, 0);
		send_beat(REQ_UNUSED_HI, 1, 0, 0);
		send_beat(REQ_DEL_POS, 1, 0, 0);

		for (int n = 0; n < 1550; n++) begin
			if (n == 400) wait (pending == 0);
			gap = (n >= 600 && n < 800) ? 0 : $urandom_range(0, 99);
			if (gap < 31) repeat ($urandom_range(1, 6)) @(negedge clk);
			random_beat(((n / 200) % 2 == 0) ? 75 : 30);
		end

		wait (pending == 0);
		repeat (600) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

[filelist.f]
hdl/sle_pkg.sv
hdl/sle_ram.sv
hdl/sle_front.sv
hdl/sle_back.sv
hdl/sequential_list_engine_top.sv
tb/sle_list_checker.sv
tb/sequential_list_engine_top_test.sv
